@@ hw/rtl/sha256_pkg.sv @@
// Shared types and constants of the SHA-256 message hash engine.
package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        P_MARK,
        P_ZERO,
        P_LEN
    } t_pad_phase;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } t_work;

    typedef logic [15:0][31:0] t_block;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ hw/rtl/sha256_message_hash.sv @@
// SHA-256 byte-stream hash engine: byte packing, padding, round sequencer, digest out.
//
//  channel   direction  signals                                     handshake
//  -------   ---------  ------------------------------------------  -----------------
//  input     in         i_data_byte, i_byte_present, i_last         i_valid / o_ready
//  digest    out        o_digest_word, o_word_index, o_last_word    o_valid / i_ready
//
// A byte that does not complete a 64-byte block is shifted into the block register.
// A block-completing byte adds a compression: 64 passes through the single round
// unit plus one hash update. Closing a message shifts 0x80, zero fill and eight
// length bytes into the block register, pausing for each of one or two compressions,
// then presents eight digest words, one per transfer. o_ready is low from the first
// cycle of that work until the eighth digest word is transferred.
// Reset is synchronous and loads the initial hash values; a stalled digest word holds.
module sha256_message_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state     r_state, n_state;
    sha256_pkg::t_state     r_after, n_after;
    sha256_pkg::t_pad_phase r_phase, n_phase;
    logic [5:0]             r_round, n_round;
    logic [5:0]             r_fill, n_fill;
    logic [60:0]            r_byte_count, n_byte_count;
    logic [2:0]             r_len_idx, n_len_idx;
    logic [2:0]             r_out_idx, n_out_idx;
    logic [31:0]            r_hash [8];
    logic [31:0]            n_hash [8];
    sha256_pkg::t_block     r_block, n_block;
    sha256_pkg::t_work      r_work, n_work;

    sha256_pkg::t_work      round_work;
    logic [31:0]            w_new;
    logic [63:0]            bit_len;
    logic [519:0]           shifted;
    logic [7:0]             shift_byte;
    logic                   shift_en;
    logic                   wrap;

    sha256_round u_round (
        .i_work  (r_work),
        .i_k     (sha256_pkg::ROUND_K[r_round]),
        .i_w0    (r_block[15]),
        .i_w1    (r_block[14]),
        .i_w9    (r_block[6]),
        .i_w14   (r_block[1]),
        .o_work  (round_work),
        .o_w_new (w_new)
    );

    assign bit_len = {r_byte_count, 3'b000};
    assign shifted = {r_block, shift_byte};
    assign wrap    = shift_en && (r_fill == sha256_pkg::FILL_LAST);

    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_phase      = r_phase;
        n_round      = r_round;
        n_fill       = r_fill;
        n_byte_count = r_byte_count;
        n_len_idx    = r_len_idx;
        n_out_idx    = r_out_idx;
        n_hash       = r_hash;
        n_block      = r_block;
        n_work       = r_work;
        shift_en     = 1'b0;
        shift_byte   = 8'h00;

        case (r_state)
            sha256_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_phase   = sha256_pkg::P_MARK;
                    n_len_idx = '0;
                    if (i_byte_present) begin
                        shift_en     = 1'b1;
                        shift_byte   = i_data_byte;
                        n_byte_count = r_byte_count + 61'd1;
                    end
                    if (i_last) begin
                        n_state = sha256_pkg::S_PAD;
                    end
                    n_after = i_last ? sha256_pkg::S_PAD : sha256_pkg::S_IDLE;
                end
            end
            sha256_pkg::S_PAD: begin
                n_after = sha256_pkg::S_PAD;
                case (r_phase)
                    sha256_pkg::P_MARK: begin
                        shift_en   = 1'b1;
                        shift_byte = sha256_pkg::PAD_MARK;
                        n_phase    = sha256_pkg::P_ZERO;
                    end
                    sha256_pkg::P_ZERO: begin
                        if (r_fill == sha256_pkg::LEN_FILL) begin
                            n_phase = sha256_pkg::P_LEN;
                        end else begin
                            shift_en = 1'b1;
                        end
                    end
                    sha256_pkg::P_LEN: begin
                        shift_en   = 1'b1;
                        shift_byte = bit_len[(3'd7 - r_len_idx) * 8 +: 8];
                        n_len_idx  = r_len_idx + 3'd1;
                        n_after    = sha256_pkg::S_OUT;
                    end
                    default: begin
                        n_phase = sha256_pkg::P_MARK;
                    end
                endcase
            end
            sha256_pkg::S_ROUND: begin
                n_work  = round_work;
                n_block = {r_block[14:0], w_new};
                n_round = r_round + 6'd1;
                if (r_round == sha256_pkg::ROUND_LAST) begin
                    n_state = sha256_pkg::S_UPDATE;
                end
            end
            sha256_pkg::S_UPDATE: begin
                n_hash[0] = r_hash[0] + r_work.a;
                n_hash[1] = r_hash[1] + r_work.b;
                n_hash[2] = r_hash[2] + r_work.c;
                n_hash[3] = r_hash[3] + r_work.d;
                n_hash[4] = r_hash[4] + r_work.e;
                n_hash[5] = r_hash[5] + r_work.f;
                n_hash[6] = r_hash[6] + r_work.g;
                n_hash[7] = r_hash[7] + r_work.h;
                n_out_idx = '0;
                n_state   = r_after;
            end
            sha256_pkg::S_OUT: begin
                if (i_ready) begin
                    for (int j = 0; j < 7; j++) begin
                        n_hash[j] = r_hash[j + 1];
                    end
                    n_hash[7] = sha256_pkg::HASH_INIT[r_out_idx];
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == sha256_pkg::WORD_LAST) begin
                        n_state      = sha256_pkg::S_IDLE;
                        n_byte_count = '0;
                        n_fill       = '0;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::S_IDLE;
            end
        endcase

        if (shift_en) begin
            n_block = shifted[511:0];
            n_fill  = r_fill + 6'd1;
        end

        if (wrap) begin
            n_state = sha256_pkg::S_ROUND;
            n_round = '0;
            n_work  = '{a: r_hash[0], b: r_hash[1], c: r_hash[2], d: r_hash[3],
                        e: r_hash[4], f: r_hash[5], g: r_hash[6], h: r_hash[7]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sha256_pkg::S_IDLE;
            r_after      <= sha256_pkg::S_IDLE;
            r_phase      <= sha256_pkg::P_MARK;
            r_round      <= '0;
            r_fill       <= '0;
            r_byte_count <= '0;
            r_len_idx    <= '0;
            r_out_idx    <= '0;
            r_hash       <= sha256_pkg::HASH_INIT;
        end else begin
            r_state      <= n_state;
            r_after      <= n_after;
            r_phase      <= n_phase;
            r_round      <= n_round;
            r_fill       <= n_fill;
            r_byte_count <= n_byte_count;
            r_len_idx    <= n_len_idx;
            r_out_idx    <= n_out_idx;
            r_hash       <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block <= n_block;
        r_work  <= n_work;
    end

    assign o_ready       = (r_state == sha256_pkg::S_IDLE);
    assign o_valid       = (r_state == sha256_pkg::S_OUT);
    assign o_digest_word = r_hash[0];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == sha256_pkg::WORD_LAST);

endmodule

@@ hw/rtl/sha256_round.sv @@
// One SHA-256 compression round with the next message schedule word.
module sha256_round (
    input  sha256_pkg::t_work i_work,
    input  logic [31:0]       i_k,
    input  logic [31:0]       i_w0,
    input  logic [31:0]       i_w1,
    input  logic [31:0]       i_w9,
    input  logic [31:0]       i_w14,
    output sha256_pkg::t_work o_work,
    output logic [31:0]       o_w_new
);

    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] small_s0;
    logic [31:0] small_s1;

    always_comb begin
        big_s1 = sha256_pkg::rotr(i_work.e, 6) ^ sha256_pkg::rotr(i_work.e, 11)
               ^ sha256_pkg::rotr(i_work.e, 25);
        big_s0 = sha256_pkg::rotr(i_work.a, 2) ^ sha256_pkg::rotr(i_work.a, 13)
               ^ sha256_pkg::rotr(i_work.a, 22);
        ch     = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        maj    = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);
        t1     = i_work.h + big_s1 + ch + i_k + i_w0;
        t2     = big_s0 + maj;

        o_work.h = i_work.g;
        o_work.g = i_work.f;
        o_work.f = i_work.e;
        o_work.e = i_work.d + t1;
        o_work.d = i_work.c;
        o_work.c = i_work.b;
        o_work.b = i_work.a;
        o_work.a = t1 + t2;

        small_s0 = sha256_pkg::rotr(i_w1, 7) ^ sha256_pkg::rotr(i_w1, 18) ^ (i_w1 >> 3);
        small_s1 = sha256_pkg::rotr(i_w14, 17) ^ sha256_pkg::rotr(i_w14, 19)
                 ^ (i_w14 >> 10);
        o_w_new  = small_s1 + i_w9 + small_s0 + i_w0;
    end

endmodule

@@ bench/sha256_message_hash_tb.sv @@
// Self-checking testbench for the SHA-256 byte-stream hash engine.
`timescale 1ns / 1ps

module sha256_message_hash_tb;

    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 9;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          ITEM_TARGET  = 170;
    localparam int          IDLE_PCT     = 9;
    localparam int          MAX_PRINTS   = 60;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam int unsigned LEN_POS      = 56;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K256 [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } t_digest_exp;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_last         = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    logic [31:0] hash_state [8];
    logic [31:0] sched [16];
    logic [60:0] msg_bytes;
    t_digest_exp digests_due [$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  quiet_cycles = 0;
    int  hold_pending = 0;
    bit  steady       = 1'b0;

    sha256_message_hash dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, maj, w2, w15;
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                w2  = sched[(t - 2) % 16];
                w15 = sched[(t - 15) % 16];
                s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
                s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
                sched[t % 16] = s1 + sched[(t - 7) % 16] + s0 + sched[t % 16];
            end
            s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + K256[t] + sched[t % 16];
            s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
    endfunction

    function automatic void pack_byte(input int unsigned pos, input logic [7:0] b);
        int unsigned idx;
        int unsigned sh;
        idx = (pos >> 2) & 15;
        sh  = (3 - (pos & 3)) * 8;
        if ((pos & 3) == 0) sched[idx] = {b, 24'h000000};
        else sched[idx] = sched[idx] | (32'(b) << sh);
    endfunction

    function automatic void predict_digest(input logic [7:0] b, input logic present,
                                           input logic last);
        int unsigned pos;
        logic [63:0] bits;
        t_digest_exp e;
        if (present) begin
            pack_byte(msg_bytes[5:0], b);
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0) compress_block();
        end
        if (!last) return;
        pos = msg_bytes[5:0];
        pack_byte(pos, PAD_BYTE);
        for (int j = (pos >> 2) + 1; j < 16; j++) sched[j] = 32'h0;
        if (pos >= LEN_POS) begin
            compress_block();
            for (int j = 0; j < 16; j++) sched[j] = 32'h0;
        end
        bits = {msg_bytes, 3'b000};
        sched[14] = bits[63:32];
        sched[15] = bits[31:0];
        compress_block();
        for (int j = 0; j < 8; j++) begin
            e.word    = hash_state[j];
            e.index   = 3'(j);
            e.is_last = (j == 7);
            digests_due.push_back(e);
        end
        hash_state = HASH_IV;
        msg_bytes  = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= present;
        i_last         <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_digest(b, present, last);
        if (present || last) items_sent++;
    endtask

    task automatic send_message(input int len, input bit close_empty);
        bit tail;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 4) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            tail = (k == len - 1) && !close_empty;
            send_item(8'($urandom_range(0, 255)), 1'b1, tail);
        end
        if (close_empty || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        i_valid <= 1'b0;
        while (digests_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_message();
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_single_bytes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_back_pressure();
        hold_pending = HOLD_CYCLES;
        for (int m = 0; m < 3; m++) send_message($urandom_range(1, 6), 1'b0);
    endtask

    task automatic test_drain_pause();
        send_message($urandom_range(1, 10), 1'b0);
        wait_digests_drained();
        send_message($urandom_range(1, 10), 1'b1);
    endtask

    task automatic test_random_messages();
        int len;
        int msgs;
        msgs  = 0;
        steady = 1'b1;
        while (items_sent < ITEM_TARGET || msgs < 4) begin
            if (msgs == 3) steady = 1'b0;
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end else begin
                len = $urandom_range(0, 16);
            end
            send_message(len, $urandom_range(0, 3) == 0);
            msgs++;
        end
        steady = 1'b0;
    endtask

    initial begin : digest_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pending > 0) begin
                hold_left    = hold_pending;
                hold_pending = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : digest_check
        t_digest_exp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (digests_due.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, 32'h0);
            end else begin
                e = digests_due.pop_front();
                if (o_digest_word !== e.word)
                    report_mismatch("digest word", o_digest_word, e.word);
                if (o_word_index !== e.index)
                    report_mismatch("word index", 32'(o_word_index), 32'(e.index));
                if (o_last_word !== e.is_last)
                    report_mismatch("last word", 32'(o_last_word), 32'(e.is_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        hash_state = HASH_IV;
        for (int j = 0; j < 16; j++) sched[j] = 32'h0;
        msg_bytes = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_message();
        test_single_bytes();
        test_back_pressure();
        test_drain_pause();
        test_random_messages();
        i_valid <= 1'b0;
        while (digests_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sha256_message_hash.f @@
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_round.sv
hw/rtl/sha256_message_hash.sv
bench/sha256_message_hash_tb.sv
